/* hw/rtl/sorted_name_index_lookup_macros.svh */
`ifndef SORTED_NAME_INDEX_LOOKUP_MACROS_SVH
`define SORTED_NAME_INDEX_LOOKUP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define SNIL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SNIL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/snil_pkg.sv */
package snil_pkg;

	localparam int MAX_RECORDS_DEF = 1024;
	localparam int CFG_W = 11;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_BUILD  = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [10:0] entry_index;
		logic [63:0] name_key;
		logic [31:0] entry_offset;
		logic [31:0] skip_bytes;
		logic [31:0] buffer_capacity;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [10:0] record_number;
		logic [31:0] data_offset;
		logic [31:0] record_size;
		logic        fits_buffer;
		logic        bad_request;
	} out_item_t;

endpackage

/* hw/rtl/snil_ram.sv */
module snil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/sorted_name_index_lookup.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item   (snil_pkg::in_item_t)
// out       output     out_valid / out_ready  out_item  (snil_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_data  (record_count, 11 bits)
//
// Load and ignored opcodes finish at the accepting edge; the result shows next cycle.
// Lookup on an empty table finishes at the accepting edge; else binary search over
// one key/position RAM read port, then final compares and two offset reads.
// Build: insertion sort (O(n^2)) through S_B_NEXT, S_B_KEY, S_B_PROBE and S_B_SHIFT.
// Reset clears control and record_count only; tables are valid once loaded/built.
// A new item is taken only when the block is idle and the result slot frees up.
`include "sorted_name_index_lookup_macros.svh"

module sorted_name_index_lookup #(
	parameter int MAX_RECORDS = snil_pkg::MAX_RECORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  snil_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output snil_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [snil_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW   = $clog2(MAX_RECORDS);
	localparam int CNTW = $clog2(MAX_RECORDS + 1);
	localparam int OAW  = CNTW;
	localparam int WW   = (CNTW > snil_pkg::CFG_W) ? CNTW : snil_pkg::CFG_W;
	localparam int RW   = (AW + 1 > 11) ? AW + 1 : 11;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_B_NEXT  = 11'b00000000010,
		S_B_KEY   = 11'b00000000100,
		S_B_PROBE = 11'b00000001000,
		S_B_SHIFT = 11'b00000010000,
		S_L_MID   = 11'b00000100000,
		S_L_CMP   = 11'b00001000000,
		S_L_LO    = 11'b00010000000,
		S_L_HI    = 11'b00100000000,
		S_L_OF1   = 11'b01000000000,
		S_L_OF2   = 11'b10000000000
	} state_t;

	state_t                     state_q;
	logic [snil_pkg::CFG_W-1:0] count_q;
	logic                       out_valid_q;
	snil_pkg::out_item_t        out_q;
	logic [CNTW-1:0]            i_q;
	logic [AW-1:0]              j_q, lo_q, hi_q, pos_q;
	logic [63:0]                key_q;
	logic [31:0]                skip_q, cap_q, start_q;

	logic [WW-1:0]   rc_w, idx_w;
	logic [CNTW-1:0] n_c, n_m1;
	logic            accept;
	logic            done_w;
	logic [AW:0]     mid_sum;
	logic [AW-1:0]   mid, span;

	logic            name_we, ofs_we, srt_we;
	logic [AW-1:0]   name_waddr, name_raddr, srt_waddr, srt_raddr, pos_wdata;
	logic [OAW-1:0]  ofs_waddr, ofs_raddr;
	logic [63:0]     name_rdata, srt_wdata, srt_rdata;
	logic [31:0]     ofs_rdata, size_w, rem_w;
	logic [AW-1:0]   pos_rdata;
	logic [RW-1:0]   rec_w;

	snil_pkg::out_item_t start_res_w, hit_res_w;

	snil_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_name (
		.clk(clk), .we(name_we), .waddr(name_waddr), .wdata(in_item.name_key),
		.raddr(name_raddr), .rdata(name_rdata)
	);
	snil_ram #(.WIDTH(32), .DEPTH(MAX_RECORDS + 1)) u_ofs (
		.clk(clk), .we(ofs_we), .waddr(ofs_waddr), .wdata(in_item.entry_offset),
		.raddr(ofs_raddr), .rdata(ofs_rdata)
	);
	snil_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_skey (
		.clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
		.raddr(srt_raddr), .rdata(srt_rdata)
	);
	snil_ram #(.WIDTH(AW), .DEPTH(MAX_RECORDS)) u_spos (
		.clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(pos_wdata),
		.raddr(srt_raddr), .rdata(pos_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Clamp the count to the table capacity
	assign rc_w  = WW'(count_q);
	assign idx_w = WW'(in_item.entry_index);
	assign n_c   = (rc_w > WW'(MAX_RECORDS)) ? CNTW'(MAX_RECORDS) : rc_w[CNTW-1:0];
	assign n_m1  = n_c - CNTW'(1);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[AW:1];
	assign span    = hi_q - lo_q;
	assign size_w  = ofs_rdata - start_q;
	assign rem_w   = size_w - skip_q;
	assign rec_w   = RW'(pos_q) + RW'(1);

	// Result is complete at this edge
	assign done_w = (accept && in_item.operation != snil_pkg::OP_BUILD
			&& !(in_item.operation == snil_pkg::OP_LOOKUP && n_c != '0))
		|| (state_q == S_B_NEXT && i_q == n_c)
		|| (state_q == S_L_HI && srt_rdata != key_q)
		|| (state_q == S_L_OF2);

	always_comb begin
		start_res_w = '0;
		start_res_w.bad_request = (in_item.operation == snil_pkg::OP_LOAD)
			&& (idx_w > WW'(n_c));
		hit_res_w = '0;
		hit_res_w.found         = 1'b1;
		hit_res_w.record_number = rec_w[10:0];
		hit_res_w.data_offset   = start_q;
		hit_res_w.record_size   = size_w;
		hit_res_w.fits_buffer   = rem_w <= cap_q;
	end

	always_comb begin
		name_we    = 1'b0;
		ofs_we     = 1'b0;
		srt_we     = 1'b0;
		name_waddr = idx_w[AW-1:0];
		ofs_waddr  = idx_w[OAW-1:0];
		name_raddr = i_q[AW-1:0];
		srt_waddr  = j_q;
		srt_wdata  = key_q;
		pos_wdata  = i_q[AW-1:0];
		srt_raddr  = j_q - AW'(1);
		ofs_raddr  = OAW'(pos_q) + OAW'(1);
		if (accept && in_item.operation == snil_pkg::OP_LOAD && idx_w <= WW'(n_c)) begin
			ofs_we  = 1'b1;
			name_we = idx_w < WW'(MAX_RECORDS);
		end
		unique case (state_q)
			S_B_SHIFT: begin
				srt_we = 1'b1;
				if (srt_rdata > key_q) begin
					srt_wdata = srt_rdata;
					pos_wdata = pos_rdata;
				end
			end
			S_B_PROBE: begin
				srt_we = (j_q == '0);
			end
			S_L_MID: begin
				srt_raddr = (span > AW'(1)) ? mid : lo_q;
			end
			S_L_LO: begin
				srt_raddr = hi_q;
				ofs_raddr = OAW'(pos_rdata);
			end
			S_L_HI: begin
				ofs_raddr = OAW'(pos_rdata);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (done_w) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_item.operation == snil_pkg::OP_BUILD) begin
							state_q <= S_B_NEXT;
						end else if (in_item.operation == snil_pkg::OP_LOOKUP && n_c != '0) begin
							state_q <= S_L_MID;
						end
					end
				end
				S_B_NEXT:  state_q <= (i_q == n_c) ? S_IDLE : S_B_KEY;
				S_B_KEY:   state_q <= S_B_PROBE;
				S_B_PROBE: state_q <= (j_q == '0) ? S_B_NEXT : S_B_SHIFT;
				S_B_SHIFT: state_q <= (srt_rdata > key_q) ? S_B_PROBE : S_B_NEXT;
				S_L_MID:   state_q <= (span > AW'(1)) ? S_L_CMP : S_L_LO;
				S_L_CMP:   state_q <= S_L_MID;
				S_L_LO:    state_q <= (srt_rdata == key_q) ? S_L_OF1 : S_L_HI;
				S_L_HI:    state_q <= (srt_rdata == key_q) ? S_L_OF1 : S_IDLE;
				S_L_OF1:   state_q <= S_L_OF2;
				S_L_OF2:   state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// Hold the waiting result until a new item is taken
				if (accept) begin
					key_q  <= in_item.name_key;
					skip_q <= in_item.skip_bytes;
					cap_q  <= in_item.buffer_capacity;
					i_q    <= '0;
					lo_q   <= '0;
					hi_q   <= n_m1[AW-1:0];
					out_q  <= start_res_w;
				end
			end
			S_B_KEY: begin
				key_q <= name_rdata;
				j_q   <= i_q[AW-1:0];
			end
			S_B_PROBE: begin
				if (j_q == '0) begin
					i_q <= i_q + CNTW'(1);
				end
			end
			S_B_SHIFT: begin
				// Shift the larger entry up, or drop the new key into its slot
				if (srt_rdata > key_q) begin
					j_q <= j_q - AW'(1);
				end else begin
					i_q <= i_q + CNTW'(1);
				end
			end
			S_L_CMP: begin
				if (srt_rdata <= key_q) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid;
				end
			end
			S_L_LO, S_L_HI: begin
				pos_q <= pos_rdata;
			end
			S_L_OF1: begin
				start_q <= ofs_rdata;
			end
			S_L_OF2: begin
				out_q <= hit_res_w;
			end
			default: begin
			end
		endcase
	end

	`SNIL_ASSERT_NOW(a_accept_idle, accept, state_q == S_IDLE, "item accepted while busy")
	`SNIL_ASSERT_NEXT(a_lookup_busy,
		accept && in_item.operation == snil_pkg::OP_LOOKUP && n_c != '0,
		state_q == S_L_MID && !out_valid_q, "lookup did not start search")
	`SNIL_ASSERT_NOW(a_miss_zero, out_valid_q && !out_q.found,
		out_q.record_number == '0 && out_q.record_size == '0, "miss carries data")

endmodule

/* tb/tb_sorted_name_index_lookup.sv */
`timescale 1ns / 100ps

module tb_sorted_name_index_lookup;

	localparam int MAXR = snil_pkg::MAX_RECORDS_DEF;
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int IDLE_LIMIT = 400000;
	localparam int TOTAL_ITEMS = 950;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	snil_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	snil_pkg::out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [snil_pkg::CFG_W-1:0] cfg_data;

	sorted_name_index_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow of the block's tables
	bit [snil_pkg::CFG_W-1:0] count_q;
	bit [63:0] names_q [MAXR];
	bit [31:0] offsets_q [MAXR+1];
	bit [63:0] sorted_q [MAXR];
	bit [9:0] origin_q [MAXR];

	snil_pkg::out_item_t pending_results [$];
	int fail_count;
	int items_sent;
	int results_seen;
	int lookups_hit;
	int burst_left;
	int rx_cycle;
	int rx_mode;
	int idle_cycles;

	typedef struct {
		bit is_cfg;
		bit [snil_pkg::CFG_W-1:0] count;
		snil_pkg::in_item_t item;
		bit typed;
		snil_pkg::out_item_t want;
	} stim_row_t;

	stim_row_t dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned live_count();
		return (count_q > MAXR) ? MAXR : count_q;
	endfunction

	function automatic snil_pkg::out_item_t predict_result(snil_pkg::in_item_t it);
		snil_pkg::out_item_t r;
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned j;
		int unsigned rec;
		bit [63:0] k;
		bit [31:0] sz;
		r = '0;
		n = live_count();
		case (it.operation)
			snil_pkg::OP_LOAD: begin
				if (it.entry_index > n) begin
					r.bad_request = 1'b1;
				end else begin
					if (it.entry_index < MAXR) names_q[it.entry_index] = it.name_key;
					offsets_q[it.entry_index] = it.entry_offset;
				end
			end
			snil_pkg::OP_BUILD: begin
				for (int unsigned i = 0; i < n; i++) begin
					k = names_q[i];
					j = i;
					while (j > 0 && sorted_q[j-1] > k) begin
						sorted_q[j] = sorted_q[j-1];
						origin_q[j] = origin_q[j-1];
						j--;
					end
					sorted_q[j] = k;
					origin_q[j] = i[9:0];
				end
			end
			snil_pkg::OP_LOOKUP: begin
				rec = 0;
				if (n != 0) begin
					lo = 0;
					hi = n - 1;
					while (hi - lo > 1) begin
						mid = (lo + hi) / 2;
						if (sorted_q[mid] <= it.name_key) lo = mid;
						else hi = mid;
					end
					if (sorted_q[lo] == it.name_key) rec = origin_q[lo] + 1;
					else if (sorted_q[hi] == it.name_key) rec = origin_q[hi] + 1;
				end
				if (rec != 0) begin
					sz = offsets_q[rec] - offsets_q[rec-1];
					r.found = 1'b1;
					r.record_number = rec[10:0];
					r.data_offset = offsets_q[rec-1];
					r.record_size = sz;
					r.fits_buffer = (sz - it.skip_bytes) <= it.buffer_capacity;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic snil_pkg::in_item_t mk_item(bit [1:0] op, bit [10:0] idx,
			bit [63:0] key, bit [31:0] offs, bit [31:0] skip, bit [31:0] cap);
		snil_pkg::in_item_t it;
		it.operation = op;
		it.entry_index = idx;
		it.name_key = key;
		it.entry_offset = offs;
		it.skip_bytes = skip;
		it.buffer_capacity = cap;
		return it;
	endfunction

	function automatic snil_pkg::in_item_t mk_load(bit [10:0] idx, bit [63:0] key,
			bit [31:0] offs);
		return mk_item(snil_pkg::OP_LOAD, idx, key, offs, $urandom, $urandom);
	endfunction

	function automatic snil_pkg::in_item_t mk_lookup(bit [63:0] key, bit [31:0] skip,
			bit [31:0] cap);
		return mk_item(snil_pkg::OP_LOOKUP, 11'($urandom_range(0, 2047)), key, $urandom,
			skip, cap);
	endfunction

	function automatic void cmp_field(string fname, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, e, a);
			fail_count++;
		end
	endfunction

	task automatic send(snil_pkg::in_item_t it, bit typed = 1'b0,
			snil_pkg::out_item_t want = '0);
		snil_pkg::out_item_t r;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		r = predict_result(it);
		pending_results.push_back(typed ? want : r);
		items_sent++;
		burst_left--;
	endtask

	// hold the sender until the block drains, then write the register
	task automatic set_count(bit [snil_pkg::CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		count_q = v;
		cfg_valid <= 1'b0;
		burst_left = 0;
	endtask

	function automatic bit [63:0] pick_key(int i, bit [63:0] prev);
		bit [63:0] k;
		case ($urandom_range(0, 7))
			0: k = prev;
			1: k = $urandom_range(0, 1) ? 64'd0 : '1;
			2, 3: begin
				k = '0;
				for (int c = 0; c < $urandom_range(1, 8); c++)
					k[63-8*c -: 8] = 8'($urandom_range(8'h21, 8'h7e));
			end
			default: k = {$urandom, $urandom};
		endcase
		return k;
	endfunction

	// receiver: stall pattern is redrawn at random among four modes
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, got 0x%0h", $time, out_item);
				fail_count++;
			end else begin
				snil_pkg::out_item_t w;
				w = pending_results.pop_front();
				cmp_field("found", w.found, out_item.found);
				cmp_field("record_number", w.record_number, out_item.record_number);
				cmp_field("data_offset", w.data_offset, out_item.data_offset);
				cmp_field("record_size", w.record_size, out_item.record_size);
				cmp_field("fits_buffer", w.fits_buffer, out_item.fits_buffer);
				cmp_field("bad_request", w.bad_request, out_item.bad_request);
				if (out_item.found) lookups_hit++;
				results_seen++;
			end
		end
		rx_cycle++;
		if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((rx_cycle / 8) % 2 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int nl;
		int order [$];
		bit [63:0] keys [$];
		bit [63:0] k;
		bit [31:0] offs;
		bit [31:0] skip;
		bit [31:0] cap;
		snil_pkg::out_item_t bad;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rx_mode = 0;
		burst_left = 0;
		count_q = '0;
		foreach (names_q[i]) names_q[i] = '0;
		foreach (offsets_q[i]) offsets_q[i] = '0;
		foreach (sorted_q[i]) sorted_q[i] = '0;
		foreach (origin_q[i]) origin_q[i] = '0;
		bad = '0;
		bad.bad_request = 1'b1;

		// directed: empty table, range errors, ignored opcode, then a two-record table
		dir_rows.push_back('{0, 0, mk_load(0, 0, 0), 1, '0});
		dir_rows.push_back('{0, 0, mk_load(1, '1, '1), 1, bad});
		dir_rows.push_back('{0, 0, mk_load(11'd2047, '1, '1), 1, bad});
		dir_rows.push_back('{0, 0, mk_item(snil_pkg::OP_BUILD, 0, 0, 0, 0, 0), 1, '0});
		dir_rows.push_back('{0, 0, mk_lookup(0, 0, 0), 1, '0});
		dir_rows.push_back('{0, 0, mk_item(OP_IGNORED, '1, '1, '1, '1, '1), 1, '0});
		dir_rows.push_back('{1, 2, '0, 0, '0});
		dir_rows.push_back('{0, 0, mk_load(0, '1, '1), 1, '0});
		dir_rows.push_back('{0, 0, mk_load(1, 0, 32'd10), 1, '0});
		dir_rows.push_back('{0, 0, mk_load(2, 64'h4100_0000_0000_0000, 32'd5), 1, '0});
		dir_rows.push_back('{0, 0, mk_load(3, 0, 0), 1, bad});
		dir_rows.push_back('{0, 0, mk_item(snil_pkg::OP_BUILD, '1, '1, '1, '1, '1), 1, '0});
		dir_rows.push_back('{0, 0, mk_lookup('1, 0, '1), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup('1, '1, 0), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup(0, 0, 0), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup(0, 32'd1, 32'd4), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup(0, '1, '1), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup(64'h4100_0000_0000_0000, 0, '1), 1, '0});
		dir_rows.push_back('{0, 0, mk_lookup(64'h1, 0, '1), 1, '0});
		dir_rows.push_back('{1, 1, '0, 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup('1, 0, 0), 0, '0});
		dir_rows.push_back('{0, 0, mk_lookup(0, 0, 0), 0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) set_count(dir_rows[i].count);
			else send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end

		// count above capacity: the load range check clamps to the table size
		set_count(11'd2047);
		send(mk_load(11'd1024, '1, 32'd7));
		send(mk_load(11'd1025, '1, '1), 1'b1, bad);
		set_count(11'd1024);
		send(mk_load(11'd1024, 0, 32'd9));
		send(mk_load(11'd1025, 0, 0), 1'b1, bad);

		while (items_sent < TOTAL_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			set_count(11'(n));
			order.delete();
			keys.delete();
			for (int i = 0; i <= n; i++) order.push_back(i);
			order.shuffle();
			k = '0;
			for (int i = 0; i <= n; i++) begin
				k = pick_key(i, k);
				keys.push_back(k);
			end
			offs = $urandom;
			for (int i = 0; i <= n; i++) begin
				if ($urandom_range(0, 9) == 0)
					send(mk_item(OP_IGNORED, 11'($urandom), {$urandom, $urandom}, $urandom,
						$urandom, $urandom));
				if ($urandom_range(0, 9) == 0)
					send(mk_load(11'($urandom_range(n + 1, 2047)), {$urandom, $urandom},
						$urandom));
				offs = $urandom_range(0, 1) ? $urandom : offs + $urandom_range(0, 300);
				send(mk_load(11'(order[i]), keys[order[i]], offs));
			end
			send(mk_item(snil_pkg::OP_BUILD, 11'($urandom), {$urandom, $urandom}, $urandom,
				$urandom, $urandom));
			nl = $urandom_range(3, 30);
			for (int i = 0; i < nl; i++) begin
				k = (n > 0 && $urandom_range(0, 9) < 7) ? keys[$urandom_range(0, n - 1)]
					: pick_key(0, {$urandom, $urandom});
				case ($urandom_range(0, 3))
					0: skip = 0;
					1: skip = $urandom_range(0, 400);
					default: skip = $urandom;
				endcase
				case ($urandom_range(0, 3))
					0: cap = 0;
					1: cap = '1;
					2: cap = $urandom_range(0, 400);
					default: cap = $urandom;
				endcase
				send(mk_lookup(k, skip, cap));
			end
			// shrink the count after the build and search the shorter table
			if (n > 1 && $urandom_range(0, 5) == 0) begin
				set_count(11'($urandom_range(0, n - 1)));
				for (int i = 0; i < 5; i++)
					send(mk_lookup(keys[$urandom_range(0, n - 1)], $urandom, $urandom));
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d lookups found a record.",
			items_sent, results_seen, lookups_hit);
		$display("Counts covered: zero, small, up to 64, and above capacity on the load check.");
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
